// ===== src/cldq_pkg.sv =====
// ----------------------------------------------------------------------------
// cldq_pkg
// shared constants, opcode values and transaction types for the circular
// linked deque manager
// ----------------------------------------------------------------------------
package cldq_pkg;

  localparam int NODES = 256;
  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W = $clog2(NODES + 1);

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_REMOVE    = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT = 3'd3;
  localparam logic [2:0] KIND_POP_BACK  = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] node_id;
  } req_t;

  typedef struct packed {
    logic [7:0] out_node;
    logic       out_valid;
    logic       is_empty;
    logic [8:0] node_count;
    logic [7:0] front_node;
    logic [7:0] back_node;
  } rsp_t;

  // one write port and one read address for a link store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } link_port_t;

endpackage

// ===== src/cldq_ram.sv =====
// ----------------------------------------------------------------------------
// cldq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cldq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cldq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cldq_ctrl
// operation sequencer: holds head, tail and count, drives the link rams
// through read, walk and write-back steps
// ----------------------------------------------------------------------------
module cldq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  cldq_pkg::req_t                 req,
  output cldq_pkg::link_port_t           next_port,
  output cldq_pkg::link_port_t           prev_port,
  input  logic [cldq_pkg::IDX_W-1:0]     next_rdata,
  input  logic [cldq_pkg::IDX_W-1:0]     prev_rdata,
  output logic                           res_load,
  output cldq_pkg::rsp_t                 res,
  input  logic                           out_free
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_A,
    S_INS_B,
    S_WALK,
    S_UNL_RD,
    S_UNL_WR,
    S_FINISH
  } state_t;

  state_t                       state;
  logic                         op_front;
  logic [cldq_pkg::IDX_W-1:0]   node;
  logic [cldq_pkg::IDX_W-1:0]   victim;
  logic [cldq_pkg::CNT_W-1:0]   steps;
  logic [cldq_pkg::IDX_W-1:0]   head;
  logic [cldq_pkg::IDX_W-1:0]   tail;
  logic [cldq_pkg::CNT_W-1:0]   count;
  logic [cldq_pkg::IDX_W-1:0]   removed;
  logic                         removed_valid;

  logic [cldq_pkg::IDX_W-1:0]   in_idx;
  logic                         in_range;
  logic                         count_zero;
  logic                         count_one;
  logic                         count_full;
  logic [cldq_pkg::IDX_W-1:0]   walk_cur;
  logic                         walk_limit;

  assign in_idx     = cldq_pkg::IDX_W'(req.node_id);
  assign in_range   = (32'(req.node_id) < 32'(cldq_pkg::NODES));
  assign count_zero = (count == '0);
  assign count_one  = (count == cldq_pkg::CNT_W'(1));
  assign count_full = (count == cldq_pkg::CNT_W'(cldq_pkg::NODES));
  // first walk step starts at head, later steps follow the link just read
  assign walk_cur   = (steps == '0) ? head : next_rdata;
  assign walk_limit = (steps == cldq_pkg::CNT_W'(cldq_pkg::NODES));

  // nothing is taken while reset is held
  assign req_stall = rst || (state != S_IDLE);
  assign res_load  = (state == S_FINISH) && out_free;

  always_comb begin
    next_port       = '0;
    prev_port       = '0;
    next_port.raddr = victim;
    prev_port.raddr = victim;
    case (state)
      S_INS_A: begin
        next_port.we    = 1'b1;
        next_port.waddr = node;
        next_port.wdata = count_zero ? node : head;
        prev_port.we    = 1'b1;
        prev_port.waddr = node;
        prev_port.wdata = count_zero ? node : tail;
      end
      S_INS_B: begin
        next_port.we    = 1'b1;
        next_port.waddr = tail;
        next_port.wdata = node;
        prev_port.we    = 1'b1;
        prev_port.waddr = head;
        prev_port.wdata = node;
      end
      S_WALK: begin
        next_port.raddr = walk_cur;
        prev_port.raddr = walk_cur;
      end
      S_UNL_WR: begin
        // splice neighbors around the victim
        if (!count_one) begin
          next_port.we    = 1'b1;
          next_port.waddr = prev_rdata;
          next_port.wdata = next_rdata;
          prev_port.we    = 1'b1;
          prev_port.waddr = next_rdata;
          prev_port.wdata = prev_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.out_valid  = removed_valid;
    res.out_node   = removed_valid ? 8'(removed) : 8'd0;
    res.is_empty   = count_zero;
    res.node_count = 9'(count);
    res.front_node = count_zero ? 8'd0 : 8'(head);
    res.back_node  = count_zero ? 8'd0 : 8'(tail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      removed_valid <= 1'b0;
      steps         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            node          <= in_idx;
            op_front      <= (req.kind == cldq_pkg::KIND_INS_FRONT);
            removed       <= '0;
            removed_valid <= 1'b0;
            steps         <= '0;
            case (req.kind)
              cldq_pkg::KIND_INS_FRONT, cldq_pkg::KIND_INS_BACK: begin
                state <= (in_range && !count_full) ? S_INS_A : S_FINISH;
              end
              cldq_pkg::KIND_REMOVE: begin
                state <= (in_range && !count_zero) ? S_WALK : S_FINISH;
              end
              cldq_pkg::KIND_POP_FRONT: begin
                victim <= head;
                state  <= count_zero ? S_FINISH : S_UNL_RD;
              end
              cldq_pkg::KIND_POP_BACK: begin
                victim <= tail;
                state  <= count_zero ? S_FINISH : S_UNL_RD;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_INS_A: begin
          if (count_zero) begin
            head  <= node;
            tail  <= node;
            count <= count + cldq_pkg::CNT_W'(1);
            state <= S_FINISH;
          end else begin
            state <= S_INS_B;
          end
        end
        S_INS_B: begin
          if (op_front) begin
            head <= node;
          end else begin
            tail <= node;
          end
          count <= count + cldq_pkg::CNT_W'(1);
          state <= S_FINISH;
        end
        S_WALK: begin
          if (walk_limit) begin
            state <= S_FINISH;
          end else if (walk_cur == node) begin
            // links of the hit node are being read this cycle
            victim <= node;
            state  <= S_UNL_WR;
          end else if (walk_cur == tail) begin
            state <= S_FINISH;
          end else begin
            steps <= steps + cldq_pkg::CNT_W'(1);
          end
        end
        S_UNL_RD: begin
          state <= S_UNL_WR;
        end
        S_UNL_WR: begin
          if (count_one) begin
            head <= '0;
            tail <= '0;
          end else begin
            if (victim == head) begin
              head <= next_rdata;
            end
            if (victim == tail) begin
              tail <= prev_rdata;
            end
          end
          count         <= count - cldq_pkg::CNT_W'(1);
          removed       <= victim;
          removed_valid <= 1'b1;
          state         <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/cldq_outreg.sv =====
// ----------------------------------------------------------------------------
// cldq_outreg
// result register: holds one finished transaction until the consumer takes it
// ----------------------------------------------------------------------------
module cldq_outreg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  cldq_pkg::rsp_t res,
  output logic           out_free,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cldq_pkg::rsp_t rsp
);

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= res;
    end
  end

endmodule

// ===== src/circular_linked_deque_manager.sv =====
// ----------------------------------------------------------------------------
// circular_linked_deque_manager
// circular doubly linked list over a fixed node pool; next and previous
// links live in two rams, head, tail and count in registers
// ----------------------------------------------------------------------------
//  channel | signals                       | direction | payload
//  --------+-------------------------------+-----------+----------------------
//  req     | req_valid, req_stall, req     | in        | kind, node_id
//  rsp     | rsp_valid, rsp_stall, rsp     | out       | removed node, flags,
//          |                               |           | count, head, tail
//
//  an insert writes its own links, then its neighbors' links (an insert
//  into an empty list writes only its own); a pop reads the victim's
//  links, then writes back the splice.
//  a named remove walks the list one link per cycle through the
//  next-link ram read port.
//  a new request is taken while the previous result still waits in the
//  output register; the sequencer holds its result while rsp is stalled.
//  reset clears head, tail and count at once; the link rams need no clear.
// ----------------------------------------------------------------------------
module circular_linked_deque_manager (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cldq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cldq_pkg::rsp_t rsp
);

  cldq_pkg::link_port_t       next_port;
  cldq_pkg::link_port_t       prev_port;
  logic [cldq_pkg::IDX_W-1:0] next_rdata;
  logic [cldq_pkg::IDX_W-1:0] prev_rdata;
  logic                       res_load;
  cldq_pkg::rsp_t             res;
  logic                       out_free;

  cldq_ram #(
    .WIDTH (cldq_pkg::IDX_W),
    .DEPTH (cldq_pkg::NODES)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_port.we),
    .waddr (next_port.waddr),
    .wdata (next_port.wdata),
    .raddr (next_port.raddr),
    .rdata (next_rdata)
  );

  cldq_ram #(
    .WIDTH (cldq_pkg::IDX_W),
    .DEPTH (cldq_pkg::NODES)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_port.we),
    .waddr (prev_port.waddr),
    .wdata (prev_port.wdata),
    .raddr (prev_port.raddr),
    .rdata (prev_rdata)
  );

  cldq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .next_port  (next_port),
    .prev_port  (prev_port),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata),
    .res_load   (res_load),
    .res        (res),
    .out_free   (out_free)
  );

  cldq_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== src/cldq_checker.sv =====
// ----------------------------------------------------------------------------
// cldq_checker
// port-level checks on the request and result channels of the deque manager
// ----------------------------------------------------------------------------
module cldq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cldq_pkg::rsp_t rsp
);

  // a stalled result transaction holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // no result survives reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // nothing removed means the node field reads zero
  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.out_valid |-> rsp.out_node == 8'd0)
    else $error("node reported without a removal");

  // empty list reports zero count and zeroed head and tail
  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      rsp.node_count == 9'd0 && rsp.front_node == 8'd0 && rsp.back_node == 8'd0)
    else $error("empty list with nonzero view");

  // the request side is held off once a transaction has been taken
  a_stall_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken without holding off the next one");

endmodule

bind circular_linked_deque_manager cldq_checker u_cldq_checker (.*);

// ===== tb/circular_linked_deque_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_linked_deque_manager_tb
// drives insert, pop and named-remove transactions into the deque manager,
// predicts every result with a local linked list and checks each field
// ----------------------------------------------------------------------------
module circular_linked_deque_manager_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  cldq_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  cldq_pkg::rsp_t rsp;

  circular_linked_deque_manager u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // local copy of the list
  logic [7:0] fwd_link  [cldq_pkg::NODES];
  logic [7:0] back_link [cldq_pkg::NODES];
  logic [7:0] head_idx;
  logic [7:0] tail_idx;
  logic [8:0] occupancy;
  bit         on_list   [cldq_pkg::NODES];

  cldq_pkg::rsp_t expected_rsp [$];

  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  bit hold_request = 1'b0;

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int peak_occupancy  = 0;
  int deepest_walk    = 0;
  int named_misses    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void attach_node(logic [7:0] n, bit at_front);
    if (occupancy == 0) begin
      fwd_link[n]  = n;
      back_link[n] = n;
      head_idx     = n;
      tail_idx     = n;
    end else begin
      fwd_link[n]         = head_idx;
      back_link[n]        = tail_idx;
      fwd_link[tail_idx]  = n;
      back_link[head_idx] = n;
      if (at_front) head_idx = n;
      else          tail_idx = n;
    end
    occupancy++;
    on_list[n] = 1'b1;
    if (occupancy > peak_occupancy) peak_occupancy = occupancy;
  endfunction

  function automatic void detach_node(logic [7:0] n);
    logic [7:0] p;
    logic [7:0] q;
    if (occupancy == 1) begin
      head_idx = '0;
      tail_idx = '0;
    end else begin
      p = back_link[n];
      q = fwd_link[n];
      if (n == head_idx) head_idx = q;
      if (n == tail_idx) tail_idx = p;
      fwd_link[p]  = q;
      back_link[q] = p;
    end
    occupancy--;
    on_list[n] = 1'b0;
    // a duplicate insert can leave stale marks; an empty list has none
    if (occupancy == 0) begin
      foreach (on_list[i]) on_list[i] = 1'b0;
    end
  endfunction

  // walk from head toward tail, at most NODES steps
  function automatic bit find_member(logic [7:0] n);
    logic [7:0] cur;
    cur = head_idx;
    for (int steps = 0; steps < cldq_pkg::NODES; steps++) begin
      if (cur == n) return 1'b1;
      if (cur == tail_idx) return 1'b0;
      cur = fwd_link[cur];
    end
    return 1'b0;
  endfunction

  function automatic cldq_pkg::rsp_t predict_deque(cldq_pkg::req_t item);
    cldq_pkg::rsp_t res;
    res = '0;
    case (item.kind)
      cldq_pkg::KIND_INS_FRONT, cldq_pkg::KIND_INS_BACK: begin
        if (occupancy < cldq_pkg::NODES)
          attach_node(item.node_id, item.kind == cldq_pkg::KIND_INS_FRONT);
      end
      cldq_pkg::KIND_REMOVE: begin
        if (occupancy != 0 && find_member(item.node_id)) begin
          detach_node(item.node_id);
          res.out_node  = item.node_id;
          res.out_valid = 1'b1;
        end else begin
          named_misses++;
        end
      end
      cldq_pkg::KIND_POP_FRONT, cldq_pkg::KIND_POP_BACK: begin
        if (occupancy != 0) begin
          res.out_node  = (item.kind == cldq_pkg::KIND_POP_FRONT) ? head_idx : tail_idx;
          res.out_valid = 1'b1;
          detach_node(res.out_node);
        end
      end
      default: ;
    endcase
    res.is_empty   = (occupancy == 0);
    res.node_count = occupancy;
    res.front_node = (occupancy != 0) ? head_idx : '0;
    res.back_node  = (occupancy != 0) ? tail_idx : '0;
    return res;
  endfunction

  function automatic cldq_pkg::req_t make_op(logic [2:0] kind, logic [7:0] id);
    cldq_pkg::req_t item;
    item.kind    = kind;
    item.node_id = id;
    return item;
  endfunction

  function automatic logic [7:0] pick_free_id();
    logic [7:0] id;
    do id = $urandom_range(0, cldq_pkg::NODES - 1); while (on_list[id]);
    return id;
  endfunction

  // named remove of the member k links past the head
  function automatic cldq_pkg::req_t remove_at_depth(int k);
    logic [7:0] cur;
    cur = head_idx;
    repeat (k) cur = fwd_link[cur];
    if (k > deepest_walk) deepest_walk = k;
    return make_op(cldq_pkg::KIND_REMOVE, cur);
  endfunction

  // mostly well-formed traffic that steers the list toward a target size
  function automatic cldq_pkg::req_t random_op(int target);
    int r;
    int grow;
    r = $urandom_range(0, 99);
    if (r < 3) return make_op($urandom_range(5, 7), $urandom_range(0, 255));
    if (occupancy == 0 && r < 10) return make_op($urandom_range(2, 4), $urandom_range(0, 255));
    grow = (occupancy < target) ? 65 : 30;
    if (occupancy == 0 || (occupancy < cldq_pkg::NODES && $urandom_range(0, 99) < grow))
      return make_op($urandom_range(0, 1) ? cldq_pkg::KIND_INS_FRONT : cldq_pkg::KIND_INS_BACK,
                     pick_free_id());
    r = $urandom_range(0, 99);
    if (r < 40) return remove_at_depth($urandom_range(0, occupancy - 1));
    if (r < 50 && occupancy < cldq_pkg::NODES)
      return make_op(cldq_pkg::KIND_REMOVE, pick_free_id());
    if (r < 75) return make_op(cldq_pkg::KIND_POP_FRONT, $urandom_range(0, 255));
    return make_op(cldq_pkg::KIND_POP_BACK, $urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_op(input cldq_pkg::req_t item);
    if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expected_rsp.push_back(predict_deque(item));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_random(int count, bit vary_idle);
    int target;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 9))
          0:       target = $urandom_range(49, 160);
          1, 2, 3: target = $urandom_range(13, 48);
          default: target = $urandom_range(1, 12);
        endcase
        if (vary_idle) begin
          req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
          rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end
      end
      send_op(random_op(target));
    end
  endtask

  task automatic test_empty_and_basic();
    req_idle_pct = 20;
    rsp_idle_pct = 20;
    send_op(make_op(cldq_pkg::KIND_POP_FRONT, 8'h00));
    send_op(make_op(cldq_pkg::KIND_POP_BACK,  8'hFF));
    send_op(make_op(cldq_pkg::KIND_REMOVE,    8'hFF));
    send_op(make_op(3'd5, 8'h5A));
    send_op(make_op(3'd6, 8'hA5));
    send_op(make_op(3'd7, 8'hFF));
    send_op(make_op(cldq_pkg::KIND_INS_FRONT, 8'h00));
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  8'hFF));
    send_op(make_op(cldq_pkg::KIND_INS_FRONT, 8'hAA));
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  8'h55));
    send_op(make_op(3'd7, 8'h00));
    send_op(make_op(cldq_pkg::KIND_REMOVE,    8'hFF));   // middle
    send_op(make_op(cldq_pkg::KIND_REMOVE,    8'h13));   // miss
    send_op(make_op(cldq_pkg::KIND_REMOVE,    8'hAA));   // head
    send_op(make_op(cldq_pkg::KIND_REMOVE,    8'h55));   // tail
    send_op(make_op(cldq_pkg::KIND_POP_FRONT, 8'hC3));   // last node goes
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  8'h07));
    send_op(make_op(cldq_pkg::KIND_POP_BACK,  8'h3C));
    send_op(make_op(cldq_pkg::KIND_INS_FRONT, 8'h03));
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  8'h04));
    send_op(make_op(cldq_pkg::KIND_POP_FRONT, 8'h00));
    send_op(make_op(cldq_pkg::KIND_POP_BACK,  8'h00));
    // same node inserted twice, then drained
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  8'h09));
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  8'h09));
    send_op(make_op(cldq_pkg::KIND_POP_FRONT, 8'h00));
    send_op(make_op(cldq_pkg::KIND_POP_FRONT, 8'h00));
  endtask

  task automatic test_fill_to_capacity();
    int order [cldq_pkg::NODES];
    int j;
    int tmp;
    int r;
    req_idle_pct = 10;
    rsp_idle_pct = 10;
    foreach (order[i]) order[i] = i;
    for (int i = cldq_pkg::NODES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i])
      send_op(make_op($urandom_range(0, 1) ? cldq_pkg::KIND_INS_FRONT : cldq_pkg::KIND_INS_BACK,
                      order[i]));
    // full pool: both inserts are dropped
    send_op(make_op(cldq_pkg::KIND_INS_FRONT, $urandom_range(0, 255)));
    send_op(make_op(cldq_pkg::KIND_INS_BACK,  $urandom_range(0, 255)));
    send_op(remove_at_depth(occupancy - 1));
    send_op(remove_at_depth(0));
    while (occupancy != 0) begin
      r = $urandom_range(0, 2);
      if (r == 0)      send_op(make_op(cldq_pkg::KIND_POP_FRONT, $urandom_range(0, 255)));
      else if (r == 1) send_op(make_op(cldq_pkg::KIND_POP_BACK,  $urandom_range(0, 255)));
      else             send_op(remove_at_depth($urandom_range(0, occupancy - 1)));
    end
  endtask

  task automatic test_output_backpressure();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_request = 1'b1;
    repeat (24) send_op(random_op(8));
  endtask

  task automatic test_random_traffic();
    run_random(650, 1'b1);
  endtask

  task automatic test_steady_stream();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_random(100, 1'b0);
  endtask

  // result side stall: random bursts, or one long hold on request
  initial begin : rsp_side
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rsp_stall <= 1'b0;
      end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic flag_field(string field, logic [8:0] want_v, logic [8:0] got_v);
    mismatch_count++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin : check_results
    cldq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_checked++;
      if (expected_rsp.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no transaction pending, expected none actual %p",
                 $time, rsp);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.out_node !== want.out_node)
          flag_field("out_node", want.out_node, rsp.out_node);
        if (rsp.out_valid !== want.out_valid)
          flag_field("out_valid", want.out_valid, rsp.out_valid);
        if (rsp.is_empty !== want.is_empty)
          flag_field("is_empty", want.is_empty, rsp.is_empty);
        if (rsp.node_count !== want.node_count)
          flag_field("node_count", want.node_count, rsp.node_count);
        if (rsp.front_node !== want.front_node)
          flag_field("front_node", want.front_node, rsp.front_node);
        if (rsp.back_node !== want.back_node)
          flag_field("back_node", want.back_node, rsp.back_node);
      end
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               quiet, expected_rsp.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    head_idx  = '0;
    tail_idx  = '0;
    occupancy = '0;
    foreach (on_list[i]) on_list[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_basic();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_traffic();
    test_steady_stream();

    req_valid <= 1'b0;
    wait (expected_rsp.size() == 0);
    repeat (50) @(posedge clk);

    $display("covered %0d transactions and %0d results, list held up to %0d nodes",
             items_sent, results_checked, peak_occupancy);
    $display("deepest named removal walked %0d links, %0d named removes missed",
             deepest_walk, named_misses);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
